// ----- rtl/awt_pkg.sv -----
// ----------------------------------------------------------------------------
// awt_pkg
// Types and constants shared by the access watchpoint table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package awt_pkg;

  localparam int ADDR_W   = 16;
  localparam int KIND_W   = 2;
  localparam int SPACE_W  = 2;
  localparam int LEVEL_W  = 5;
  localparam int CURLVL_W = 4;
  localparam int EIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;
  localparam int SKIP_W   = 16;
  localparam int REQ_W    = 3;

  // Request codes; codes five to seven are ignored.
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RW    = 2'd2;

  localparam logic [SPACE_W-1:0] SPACE_I = 2'd1;
  localparam logic [SPACE_W-1:0] SPACE_D = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [KIND_W-1:0]  kind;
    logic [SPACE_W-1:0] space;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [ADDR_W-1:0]   address;
    logic [KIND_W-1:0]   access_kind;
    logic [SPACE_W-1:0]  space_filter;
    logic [LEVEL_W-1:0]  level_filter;
    logic                is_write;
    logic                data_space;
    logic [CURLVL_W-1:0] current_level;
    logic [EIDX_W-1:0]   entry_index;
  } request_t;

  // Match flags rippling along the row: set once any earlier live cell matched.
  typedef struct packed {
    logic add_found;
    logic rem_found;
    logic chk_found;
  } found_t;

  // Data collected along the row: the entry selected for reading and the last live entry.
  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic [KIND_W-1:0] rd_kind;
    entry_t            last;
  } bus_t;

endpackage

`default_nettype wire

// ----- rtl/awt_in_if.sv -----
// ----------------------------------------------------------------------------
// awt_in_if
// Request channel of the access watchpoint table.
// ----------------------------------------------------------------------------
`default_nettype none

interface awt_in_if;
  import awt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [ADDR_W-1:0]          address;
  logic [KIND_W-1:0]          access_kind;
  logic [SPACE_W-1:0]         space_filter;
  logic signed [LEVEL_W-1:0]  level_filter;
  logic                       is_write;
  logic                       data_space;
  logic [CURLVL_W-1:0]        current_level;
  logic [EIDX_W-1:0]          entry_index;

  modport source (
    output valid, req_type, address, access_kind, space_filter, level_filter,
           is_write, data_space, current_level, entry_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, address, access_kind, space_filter, level_filter,
           is_write, data_space, current_level, entry_index,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/awt_out_if.sv -----
// ----------------------------------------------------------------------------
// awt_out_if
// Result channel of the access watchpoint table.
// ----------------------------------------------------------------------------
`default_nettype none

interface awt_out_if;
  import awt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                hit;
  logic [ADDR_W-1:0]   entry_address;
  logic [KIND_W-1:0]   entry_kind;
  logic [ECOUNT_W-1:0] entry_count;

  modport source (
    output valid, status, hit, entry_address, entry_kind, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, hit, entry_address, entry_kind, entry_count,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/awt_cell.sv -----
// ----------------------------------------------------------------------------
// awt_cell
// One slot of the watchpoint table: holds an entry, compares it with the
// current request and passes match flags and collected data to its neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_cell #(
  parameter int CW = 5
) (
  input  wire logic             clk,
  input  wire awt_pkg::request_t req,
  input  wire logic             commit,
  input  wire logic [CW-1:0]    my_idx,
  input  wire logic [CW-1:0]    count,
  input  wire awt_pkg::entry_t   last_entry,
  input  wire awt_pkg::found_t   found_in,
  output awt_pkg::found_t        found_out,
  input  wire awt_pkg::bus_t     bus_in,
  output awt_pkg::bus_t          bus_out
);
  import awt_pkg::*;

  localparam int MW = (CW > EIDX_W) ? CW : EIDX_W;

  entry_t entry_r;

  logic live;
  logic addr_eq;
  logic add_m;
  logic rem_m;
  logic chk_m;
  logic lvl_ok;
  logic space_ok;
  logic kind_ok;
  logic rd_sel;
  logic last_sel;

  assign live    = my_idx < count;
  assign addr_eq = entry_r.addr == req.address;

  assign add_m = live && addr_eq && (entry_r.space == req.space_filter) &&
                 (entry_r.level == req.level_filter);
  assign rem_m = live && addr_eq;

  // A negative level filter accepts any level.
  assign lvl_ok   = entry_r.level[LEVEL_W-1] ||
                    (entry_r.level[CURLVL_W-1:0] == req.current_level);
  assign space_ok = !(((entry_r.space == SPACE_I) && req.data_space) ||
                      ((entry_r.space == SPACE_D) && !req.data_space));
  assign kind_ok  = (entry_r.kind == KIND_RW) ||
                    (req.is_write && (entry_r.kind == KIND_WRITE)) ||
                    (!req.is_write && (entry_r.kind == KIND_READ));
  assign chk_m    = live && addr_eq && lvl_ok && space_ok && kind_ok;

  assign found_out.add_found = found_in.add_found | add_m;
  assign found_out.rem_found = found_in.rem_found | rem_m;
  assign found_out.chk_found = found_in.chk_found | chk_m;

  assign rd_sel   = live && (MW'(my_idx) == MW'(req.entry_index));
  assign last_sel = live && (my_idx == CW'(count - CW'(1)));

  assign bus_out.rd_addr = bus_in.rd_addr | (rd_sel ? entry_r.addr : '0);
  assign bus_out.rd_kind = bus_in.rd_kind | (rd_sel ? entry_r.kind : '0);
  assign bus_out.last    = bus_in.last | (last_sel ? entry_r : '0);

  always_ff @(posedge clk) begin
    if (commit) begin
      case (req.req_type)
        REQ_ADD: begin
          if (add_m && !found_in.add_found) begin
            entry_r.kind <= req.access_kind;
          end else if ((my_idx == count) && !found_in.add_found) begin
            // Every live slot lies before this one, so no match anywhere.
            entry_r.addr  <= req.address;
            entry_r.kind  <= req.access_kind;
            entry_r.space <= req.space_filter;
            entry_r.level <= req.level_filter;
          end
        end
        REQ_REMOVE: begin
          if (rem_m && !found_in.rem_found) begin
            entry_r <= last_entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/access_watchpoint_table_unit.sv -----
// ----------------------------------------------------------------------------
// access_watchpoint_table_unit
// Table of memory-access watchpoints with add, remove, check, clear and read.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch and each produces exactly one result on out_ch.
// Every slot of the table is a cell in a row; a request is compared against
// all live cells at once and the first match ripples down the row, so add,
// remove and check find the lowest matching slot.
// A request is registered in S_IDLE; in S_EVAL the row evaluates it and the
// result is committed. A new request is taken only after the last one has
// been committed; in_ch.ready is high whenever the unit is idle, including
// while a result still waits in the output register.
// If the receiver stalls, a second request waits in the evaluate cycle until
// the output register is free. The skip_count register sits at byte address 0
// of the APB port; a write also reloads the skip counter.
// Reset empties the table and clears the skip register and counter; slot
// contents are left as they are and are not read until written again.
// ----------------------------------------------------------------------------
`default_nettype none

module access_watchpoint_table_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  awt_in_if.sink            in_ch,
  awt_out_if.source         out_ch,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import awt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > EIDX_W) ? CW : EIDX_W;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t               state_r;
  request_t             req_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [SKIP_W-1:0]    skip_count_r;
  logic [SKIP_W-1:0]    skip_left_r;
  logic [SKIP_W-1:0]    skip_left_nxt;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r;
  logic [STATUS_W-1:0]  status_nxt;
  logic                 hit_r;
  logic                 hit_nxt;
  logic [ADDR_W-1:0]    eaddr_r;
  logic [ADDR_W-1:0]    eaddr_nxt;
  logic [KIND_W-1:0]    ekind_r;
  logic [KIND_W-1:0]    ekind_nxt;
  logic [ECOUNT_W-1:0]  ecount_r;

  logic                 out_free;
  logic                 commit;
  logic                 in_fire;
  logic                 cfg_write;
  logic                 rd_bad;

  found_t               found_c [DEPTH+1];
  bus_t                 bus_c   [DEPTH+1];
  found_t               found_end;
  bus_t                 bus_end;

  assign found_c[0] = '0;
  assign bus_c[0]   = '0;
  assign found_end  = found_c[DEPTH];
  assign bus_end    = bus_c[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    awt_cell #(
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .req        (req_r),
      .commit     (commit),
      .my_idx     (CW'(i)),
      .count      (count_r),
      .last_entry (bus_end.last),
      .found_in   (found_c[i]),
      .found_out  (found_c[i+1]),
      .bus_in     (bus_c[i]),
      .bus_out    (bus_c[i+1])
    );
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = (state_r == S_EVAL) && out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata    = (paddr == 2'd0) ? {{(32-SKIP_W){1'b0}}, skip_count_r} : '0;

  assign rd_bad = MW'(req_r.entry_index) >= MW'(count_r);

  always_comb begin
    count_nxt     = count_r;
    skip_left_nxt = skip_left_r;
    status_nxt    = STATUS_OK;
    hit_nxt       = 1'b0;
    eaddr_nxt     = '0;
    ekind_nxt     = '0;
    case (req_r.req_type)
      REQ_ADD: begin
        if (!found_end.add_found) begin
          if (count_r == CW'(DEPTH)) begin
            status_nxt = STATUS_FULL;
          end else begin
            count_nxt = CW'(count_r + CW'(1));
          end
        end
      end
      REQ_REMOVE: begin
        if (found_end.rem_found) begin
          count_nxt = CW'(count_r - CW'(1));
        end
      end
      REQ_CHECK: begin
        if (found_end.chk_found) begin
          if (skip_left_r != '0) begin
            skip_left_nxt = SKIP_W'(skip_left_r - SKIP_W'(1));
          end else begin
            hit_nxt = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      REQ_READ: begin
        if (rd_bad) begin
          status_nxt = STATUS_BAD_INDEX;
        end else begin
          eaddr_nxt = bus_end.rd_addr;
          ekind_nxt = bus_end.rd_kind;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      skip_count_r <= '0;
      skip_left_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_ch.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r.req_type      <= in_ch.req_type;
            req_r.address       <= in_ch.address;
            req_r.access_kind   <= in_ch.access_kind;
            req_r.space_filter  <= in_ch.space_filter;
            req_r.level_filter  <= in_ch.level_filter;
            req_r.is_write      <= in_ch.is_write;
            req_r.data_space    <= in_ch.data_space;
            req_r.current_level <= in_ch.current_level;
            req_r.entry_index   <= in_ch.entry_index;
            state_r             <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (commit) begin
            count_r     <= count_nxt;
            skip_left_r <= skip_left_nxt;
            out_valid_r <= 1'b1;
            status_r    <= status_nxt;
            hit_r       <= hit_nxt;
            eaddr_r     <= eaddr_nxt;
            ekind_r     <= ekind_nxt;
            ecount_r    <= ECOUNT_W'(count_nxt);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_write) begin
        skip_count_r <= pwdata[SKIP_W-1:0];
        skip_left_r  <= pwdata[SKIP_W-1:0];
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.hit           = hit_r;
  assign out_ch.entry_address = eaddr_r;
  assign out_ch.entry_kind    = ekind_r;
  assign out_ch.entry_count   = ecount_r;

endmodule

`default_nettype wire
